FILE: hw/rtl/frustum_box_point_cull_assert.svh
// assertion macros shared by the frustum cull rtl
`ifndef FRUSTUM_BOX_POINT_CULL_ASSERT_SVH
`define FRUSTUM_BOX_POINT_CULL_ASSERT_SVH

// plain property, checked every cycle out of reset
`define FBPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define FBPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fbpc_pkg.sv
// shared types, widths and plane tables of the frustum cull block
package fbpc_pkg;

  // number formats
  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int MatWidth   = 32;
  localparam int CoefWidth  = MatWidth + 1;
  localparam int ProdWidth  = CoefWidth + CoordWidth;
  localparam int OffWidth   = CoefWidth + FracBits;
  localparam int SumWidth   = ((ProdWidth > OffWidth) ? ProdWidth : OffWidth) + 2;

  // geometry
  localparam int NumPlanes = 6;
  localparam int NumAxes   = 3;
  localparam int NumCols   = 4;
  localparam int NumRows   = 4;

  // job queue
  localparam int FifoDepth  = 2;
  localparam int PtrWidth   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CountWidth = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BOX   = 2'd1,
    OP_POINT = 2'd2
  } opcode_e;

  typedef logic signed [MatWidth-1:0]   mat_t;
  typedef logic signed [CoefWidth-1:0]  coef_t;
  typedef logic signed [CoordWidth-1:0] coord_t;

  // one test item after plane derivation and corner choice
  typedef struct packed {
    logic                                    is_point;
    coef_t  [NumPlanes-1:0][NumCols-1:0]     coef;
    coord_t [NumPlanes-1:0][NumAxes-1:0]     corner;
  } job_t;

  // plane order: right, left, bottom, top, far, near
  function automatic logic [1:0] plane_row(input int unsigned k);
    return 2'(k >> 1);
  endfunction

  // left, bottom and near add the row to row 3, the others subtract it
  function automatic logic plane_plus(input int unsigned k);
    return (k == 1) || (k == 2) || (k == 5);
  endfunction

endpackage

FILE: hw/rtl/frustum_box_point_cull.sv
// Frustum culling of boxes and points against a 4x4 clip matrix.
// One input channel (in_valid_i / in_ready_o) carries three kinds of beat:
// a load writes one element of the row-major clip matrix, a box test or a
// point test yields one beat on the output channel (out_valid_o /
// out_ready_i) with inside_res_o and was_point_o. Loads and unused opcodes
// yield nothing. A load takes effect for the very next beat.
// The front end derives the six planes and picks each box corner in the
// cycle a beat is accepted and writes the job into a two-entry queue.
// The back end spends three register stages on products, partial sums and
// plane signs, then holds the verdict in the output register.
// Throughput: one beat per cycle on both channels while the receiver
// keeps out_ready_i high.
// Reset clears the matrix to zero, the queue and all pipeline valid bits.
// When the receiver stalls, the back end holds still, the queue fills, and
// in_ready_o drops once it is full; loads wait for the queue as well.
module frustum_box_point_cull import fbpc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [3:0]                   matrix_index_i,
  input  logic signed [MatWidth-1:0]   matrix_value_i,
  input  logic signed [CoordWidth-1:0] min_x_i,
  input  logic signed [CoordWidth-1:0] min_y_i,
  input  logic signed [CoordWidth-1:0] min_z_i,
  input  logic signed [CoordWidth-1:0] max_x_i,
  input  logic signed [CoordWidth-1:0] max_y_i,
  input  logic signed [CoordWidth-1:0] max_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o,
  output logic                         was_point_o
);

  logic push, full, q_valid, q_pop;
  job_t push_job, q_job;

  // classify and derive planes
  fbpc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .matrix_index_i (matrix_index_i),
    .matrix_value_i (matrix_value_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  // job queue
  fbpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // distances and verdict
  fbpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (q_job),
    .job_ready_o  (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .was_point_o  (was_point_o)
  );

endmodule

FILE: hw/rtl/fbpc_fifo.sv
// short job queue between the classify front and the distance back end
module fbpc_fifo import fbpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                  mem_q [FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
    if (p == PtrWidth'(FifoDepth - 1)) begin
      return '0;
    end
    return p + PtrWidth'(1);
  endfunction

  // status
  assign full_o  = (count_q == CountWidth'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CountWidth'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

`include "frustum_box_point_cull_assert.svh"
  `FBPC_ASSERT(fifo_count_bound, count_q <= CountWidth'(FifoDepth), "fifo count above depth")
  `FBPC_ASSERT_NXT(fifo_push_grows, do_push && !do_pop, count_q == $past(count_q) + CountWidth'(1), "fifo push lost")

endmodule

FILE: hw/rtl/fbpc_front.sv
// front end: holds the clip matrix, takes beats, derives planes and box corners
module fbpc_front import fbpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [3:0]            matrix_index_i,
  input  logic signed [MatWidth-1:0]   matrix_value_i,
  input  logic signed [CoordWidth-1:0] min_x_i,
  input  logic signed [CoordWidth-1:0] min_y_i,
  input  logic signed [CoordWidth-1:0] min_z_i,
  input  logic signed [CoordWidth-1:0] max_x_i,
  input  logic signed [CoordWidth-1:0] max_y_i,
  input  logic signed [CoordWidth-1:0] max_z_i,
  input  logic                  full_i,
  output logic                  push_o,
  output job_t                  job_o
);

  mat_t   mat_q [NumRows][NumCols];
  coef_t  coef_w [NumPlanes][NumCols];
  coord_t lo_w [NumAxes];
  coord_t hi_w [NumAxes];
  logic   accept, is_load, is_test, is_point;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // opcode decode
  always_comb begin
    is_load  = 1'b0;
    is_test  = 1'b0;
    is_point = 1'b0;
    unique case (opcode_i)
      OP_LOAD:  is_load = 1'b1;
      OP_BOX:   is_test = 1'b1;
      OP_POINT: begin
        is_test  = 1'b1;
        is_point = 1'b1;
      end
      default: ;
    endcase
  end

  // clip matrix, row-major
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int c = 0; c < NumCols; c++) begin
          mat_q[r][c] <= '0;
        end
      end
    end else if (accept && is_load) begin
      mat_q[matrix_index_i[3:2]][matrix_index_i[1:0]] <= matrix_value_i;
    end
  end

  // plane coefficients: row 3 plus or minus another row
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      for (int c = 0; c < NumCols; c++) begin
        if (plane_plus(p)) begin
          coef_w[p][c] = CoefWidth'(mat_q[3][c]) + CoefWidth'(mat_q[plane_row(p)][c]);
        end else begin
          coef_w[p][c] = CoefWidth'(mat_q[3][c]) - CoefWidth'(mat_q[plane_row(p)][c]);
        end
      end
    end
  end

  assign lo_w[0] = min_x_i;
  assign lo_w[1] = min_y_i;
  assign lo_w[2] = min_z_i;
  assign hi_w[0] = max_x_i;
  assign hi_w[1] = max_y_i;
  assign hi_w[2] = max_z_i;

  // job build: positive corner per plane, points use the min fields
  always_comb begin
    job_o.is_point = is_point;
    for (int p = 0; p < NumPlanes; p++) begin
      for (int c = 0; c < NumCols; c++) begin
        job_o.coef[p][c] = coef_w[p][c];
      end
      for (int a = 0; a < NumAxes; a++) begin
        if (!is_point && (coef_w[p][a] > 0)) begin
          job_o.corner[p][a] = hi_w[a];
        end else begin
          job_o.corner[p][a] = lo_w[a];
        end
      end
    end
  end

  assign push_o = accept && is_test;

endmodule

FILE: hw/rtl/fbpc_back.sv
// back end: plane distances in three stages, verdict in the output register
module fbpc_back import fbpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic inside_res_o,
  output logic was_point_o
);

  logic signed [ProdWidth-1:0] prod_q [NumPlanes][NumAxes];
  logic signed [ProdWidth-1:0] prod_d [NumPlanes][NumAxes];
  logic signed [OffWidth-1:0]  off_q [NumPlanes];
  logic signed [OffWidth-1:0]  off_d [NumPlanes];
  logic signed [SumWidth-1:0]  part_a_q [NumPlanes];
  logic signed [SumWidth-1:0]  part_b_q [NumPlanes];
  logic signed [SumWidth-1:0]  part_a_d [NumPlanes];
  logic signed [SumWidth-1:0]  part_b_d [NumPlanes];
  logic signed [SumWidth-1:0]  sum_w [NumPlanes];
  logic [NumPlanes-1:0]        neg_q, neg_d;
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_pt_q, s2_pt_q, s3_pt_q, out_pt_q, out_in_q;
  logic adv;

  // whole pipe moves unless a result sits unclaimed
  assign adv         = !out_v_q || out_ready_i;
  assign job_ready_o = adv;

  // stage 1: products and aligned offset term
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      for (int a = 0; a < NumAxes; a++) begin
        prod_d[p][a] = ProdWidth'($signed(job_i.coef[p][a]))
                     * ProdWidth'($signed(job_i.corner[p][a]));
      end
      off_d[p] = OffWidth'($signed(job_i.coef[p][NumCols-1])) <<< FracBits;
    end
  end

  // stage 2: two partial sums per plane
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      part_a_d[p] = SumWidth'(prod_q[p][0]) + SumWidth'(prod_q[p][1]);
      part_b_d[p] = SumWidth'(prod_q[p][2]) + SumWidth'(off_q[p]);
    end
  end

  // stage 3: distance sign per plane
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      sum_w[p] = part_a_q[p] + part_b_q[p];
      neg_d[p] = sum_w[p][SumWidth-1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= job_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pt_q  <= job_i.is_point;
      s2_pt_q  <= s1_pt_q;
      s3_pt_q  <= s2_pt_q;
      out_pt_q <= s3_pt_q;
      out_in_q <= (neg_q == '0);
      prod_q   <= prod_d;
      off_q    <= off_d;
      part_a_q <= part_a_d;
      part_b_q <= part_b_d;
      neg_q    <= neg_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign inside_res_o = out_in_q;
  assign was_point_o  = out_pt_q;

`include "frustum_box_point_cull_assert.svh"
  `FBPC_ASSERT_NXT(back_s2_holds, s2_v_q && !adv, s2_v_q, "stalled stage 2 beat dropped")
  `FBPC_ASSERT_NXT(back_s1_moves, s1_v_q && adv, s2_v_q, "stage 1 beat lost on advance")

endmodule
